### rtl/core/mcpf_pkg.sv
// Shared types, constants and functions of the motor command packet framer.
`timescale 1ns / 1ps

package mcpf_pkg;

  localparam int FRAME_BUFFER_BYTES_DEF = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] DEV_ADDR_RST = 8'd128;
  localparam logic [7:0] M1_CODE_RST = 8'd0;
  localparam logic [7:0] M2_CODE_RST = 8'd4;
  localparam logic [7:0] BATT_CODE_RST = 8'd24;
  localparam logic [7:0] CURR_CODE_RST = 8'd49;
  localparam logic [7:0] VER_CODE_RST = 8'd21;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    CFG_DEV_ADDR  = 3'd0,
    CFG_M1_CODE   = 3'd1,
    CFG_M2_CODE   = 3'd2,
    CFG_BATT_CODE = 3'd3,
    CFG_CURR_CODE = 3'd4,
    CFG_VER_CODE  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_DRIVE   = 3'd1,
    KIND_BATTERY = 3'd2,
    KIND_CURRENT = 3'd3,
    KIND_VERSION = 3'd4,
    KIND_BAD     = 3'd5
  } kind_t;

  // One queue word holds every result that a single input word produces.
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [3:0][7:0] data;
    logic [4:0]      reply_len;
    logic            bad;
    logic            ovf;
    logic            fend;
  } mcpf_word_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [4:0] reply_of(input kind_t kind);
    logic [4:0] r;
    case (kind)
      KIND_DRIVE:   r = 5'd1;
      KIND_BATTERY: r = 5'd4;
      KIND_CURRENT: r = 5'd6;
      KIND_VERSION: r = 5'd27;
      default:      r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/motor_command_packet_framer.sv
// Top level of the motor command packet framer.
`timescale 1ns / 1ps

// The input channel takes one payload word per cycle; the first word of a packet is the
// command code and in_payload_end marks the last. Each accepted word is classified, run
// through the CRC-16 and turned into at most one result word of up to four bytes, which
// waits in a four-entry queue. The output channel gives one framed byte per handshake: the
// device address and payload, then the CRC high and low bytes for drive commands. An
// unknown command yields a single word with out_bad_command set and the rest of its packet
// is dropped. An accepted input word enters the queue at its accepting edge; its result is
// loaded into the output register once that register is empty or its last byte is taken.
// Input words are taken every cycle while the queue has room. The output gives at most one
// byte per cycle; a packet of n kept payload words gives n + 1 bytes (n + 2 for a read
// packet that overflows), or n + 3 for drive commands, and over a long stream the input
// rate falls to match. When the receiver stalls, the current output word holds and the
// queue fills, after which in_ready drops. Configuration writes are taken every cycle on
// the cfg port. A synchronous reset restores the default address and command codes and
// empties the queue and the packet state.

module motor_command_packet_framer
  import mcpf_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_payload_byte,
  input  logic       in_payload_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_frame_end,
  output logic [4:0] out_reply_length,
  output logic       out_bad_command,
  output logic       out_overflow,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic       q_full, q_empty, push, pop;
  mcpf_word_t push_word, q_head;

  mcpf_front #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_payload_byte(in_payload_byte),
    .in_payload_end (in_payload_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_full         (q_full),
    .push           (push),
    .push_word      (push_word)
  );

  mcpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_word(push_word),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  mcpf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tx_byte     (out_tx_byte),
    .out_frame_end   (out_frame_end),
    .out_reply_length(out_reply_length),
    .out_bad_command (out_bad_command),
    .out_overflow    (out_overflow)
  );

endmodule

### rtl/core/mcpf_front.sv
// Front end: configuration registers, command classification, CRC and word build.
`timescale 1ns / 1ps

module mcpf_front
  import mcpf_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_payload_byte,
  input  logic       in_payload_end,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       q_full,
  output logic       push,
  output mcpf_word_t push_word
);

  localparam int CW = $clog2(FRAME_BUFFER_BYTES);
  localparam logic [CW-1:0] CAP = CW'(FRAME_BUFFER_BYTES - 3);

  logic [7:0]    dev_addr_r, m1_code_r, m2_code_r, batt_code_r, curr_code_r, ver_code_r;
  logic [15:0]   addr_crc_r;
  logic [15:0]   crc_r, crc_nxt;
  logic          in_packet_r, in_packet_nxt;
  kind_t         kind_r, kind_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [15:0]   crc_b;
  kind_t         cls;

  assign in_ready = !q_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEV_ADDR_RST;
      addr_crc_r  <= crc_step(16'h0000, DEV_ADDR_RST);
      m1_code_r   <= M1_CODE_RST;
      m2_code_r   <= M2_CODE_RST;
      batt_code_r <= BATT_CODE_RST;
      curr_code_r <= CURR_CODE_RST;
      ver_code_r  <= VER_CODE_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEV_ADDR: begin
          dev_addr_r <= cfg_data;
          addr_crc_r <= crc_step(16'h0000, cfg_data);
        end
        CFG_M1_CODE:   m1_code_r <= cfg_data;
        CFG_M2_CODE:   m2_code_r <= cfg_data;
        CFG_BATT_CODE: batt_code_r <= cfg_data;
        CFG_CURR_CODE: curr_code_r <= cfg_data;
        CFG_VER_CODE:  ver_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_payload_byte == m1_code_r || in_payload_byte == m2_code_r) begin
      cls = KIND_DRIVE;
    end else if (in_payload_byte == batt_code_r) begin
      cls = KIND_BATTERY;
    end else if (in_payload_byte == curr_code_r) begin
      cls = KIND_CURRENT;
    end else if (in_payload_byte == ver_code_r) begin
      cls = KIND_VERSION;
    end else begin
      cls = KIND_BAD;
    end
  end

  // The first byte chains onto the stored CRC of the address byte.
  assign crc_b = crc_step(in_packet_r ? crc_r : addr_crc_r, in_payload_byte);

  always_comb begin
    crc_nxt = crc_r;
    in_packet_nxt = in_packet_r;
    kind_nxt = kind_r;
    drop_nxt = drop_r;
    count_nxt = count_r;
    ovf_nxt = ovf_r;
    push = 1'b0;
    push_word = '0;
    if (in_valid && in_ready) begin
      if (!in_packet_r) begin
        kind_nxt = cls;
        ovf_nxt = 1'b0;
        count_nxt = CW'(1);
        if (cls == KIND_BAD) begin
          push = 1'b1;
          push_word.bad = 1'b1;
          push_word.fend = 1'b1;
          in_packet_nxt = !in_payload_end;
          drop_nxt = !in_payload_end;
          crc_nxt = 16'h0000;
          count_nxt = '0;
        end else begin
          push = 1'b1;
          crc_nxt = crc_b;
          drop_nxt = 1'b0;
          push_word.reply_len = reply_of(cls);
          push_word.data[0] = dev_addr_r;
          push_word.data[1] = in_payload_byte;
          push_word.last_idx = 2'd1;
          in_packet_nxt = !in_payload_end;
          if (in_payload_end) begin
            push_word.fend = 1'b1;
            if (cls == KIND_DRIVE) begin
              push_word.data[2] = crc_b[15:8];
              push_word.data[3] = crc_b[7:0];
              push_word.last_idx = 2'd3;
            end
          end
        end
      end else if (drop_r) begin
        if (in_payload_end) begin
          in_packet_nxt = 1'b0;
          drop_nxt = 1'b0;
        end
      end else if (count_r < CAP) begin
        push = 1'b1;
        crc_nxt = crc_b;
        count_nxt = count_r + CW'(1);
        push_word.reply_len = reply_of(kind_r);
        push_word.ovf = ovf_r;
        push_word.data[0] = in_payload_byte;
        push_word.last_idx = 2'd0;
        if (in_payload_end) begin
          in_packet_nxt = 1'b0;
          push_word.fend = 1'b1;
          if (kind_r == KIND_DRIVE) begin
            push_word.data[1] = crc_b[15:8];
            push_word.data[2] = crc_b[7:0];
            push_word.last_idx = 2'd2;
          end
        end
      end else begin
        ovf_nxt = 1'b1;
        if (in_payload_end) begin
          in_packet_nxt = 1'b0;
          push = 1'b1;
          push_word.reply_len = reply_of(kind_r);
          push_word.ovf = 1'b1;
          push_word.fend = 1'b1;
          if (kind_r == KIND_DRIVE) begin
            push_word.data[0] = crc_r[15:8];
            push_word.data[1] = crc_r[7:0];
            push_word.last_idx = 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      in_packet_r <= 1'b0;
      kind_r <= KIND_NONE;
      drop_r <= 1'b0;
      count_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      crc_r <= crc_nxt;
      in_packet_r <= in_packet_nxt;
      kind_r <= kind_nxt;
      drop_r <= drop_nxt;
      count_r <= count_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

### rtl/core/mcpf_queue.sv
// Short queue of result words between the front end and the output serializer.
`timescale 1ns / 1ps

module mcpf_queue
  import mcpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  mcpf_word_t push_word,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output mcpf_word_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  mcpf_word_t    mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r;

  assign full = (cnt_r == NW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

endmodule

### rtl/core/mcpf_back.sv
// Back end: unpacks queued words into one output byte per handshake.
`timescale 1ns / 1ps

module mcpf_back
  import mcpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  mcpf_word_t q_head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_frame_end,
  output logic [4:0] out_reply_length,
  output logic       out_bad_command,
  output logic       out_overflow
);

  mcpf_word_t cur_r;
  logic       valid_r;
  logic [1:0] idx_r;
  logic       at_last;

  assign at_last = (idx_r == cur_r.last_idx);
  assign pop = !q_empty && (!valid_r || (out_ready && at_last));

  assign out_valid = valid_r;
  assign out_tx_byte = cur_r.data[idx_r];
  assign out_frame_end = cur_r.fend && at_last;
  assign out_reply_length = cur_r.reply_len;
  assign out_bad_command = cur_r.bad;
  assign out_overflow = cur_r.ovf;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r <= '0;
    end else if (pop) begin
      valid_r <= 1'b1;
      idx_r <= '0;
    end else if (valid_r && out_ready) begin
      if (at_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

### sim/tb.sv
// Self-checking testbench of the motor command packet framer, with its own frame predictor.
`timescale 1ns / 1ps

module tb;
  import mcpf_pkg::*;

  localparam int PAYLOAD_CAP = FRAME_BUFFER_BYTES_DEF - 3;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT = 5000;

  typedef struct packed {
    logic [7:0] tx;
    logic       fend;
    logic [4:0] rlen;
    logic       bad;
    logic       ovf;
  } frame_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_payload_byte = 8'h00;
  logic       in_payload_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_tx_byte;
  logic       out_frame_end;
  logic [4:0] out_reply_length;
  logic       out_bad_command;
  logic       out_overflow;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = 3'd0;
  logic [7:0] cfg_data = 8'h00;

  frame_word_t pending_tx[$];
  logic [7:0]  cfg_regs[6];
  logic [15:0] crc_acc = 16'h0000;
  logic        pkt_open = 1'b0;
  kind_t       pkt_kind = KIND_NONE;
  logic        pkt_drop = 1'b0;
  int          pkt_count = 0;
  logic        pkt_ovf = 1'b0;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_cycles = 0;
  int err_count = 0;
  int words_sent = 0;

  always #10 clk = ~clk;

  motor_command_packet_framer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_payload_byte  (in_payload_byte),
    .in_payload_end   (in_payload_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tx_byte      (out_tx_byte),
    .out_frame_end    (out_frame_end),
    .out_reply_length (out_reply_length),
    .out_bad_command  (out_bad_command),
    .out_overflow     (out_overflow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic kind_t classify_code(input logic [7:0] code);
    if (code == cfg_regs[CFG_M1_CODE] || code == cfg_regs[CFG_M2_CODE]) return KIND_DRIVE;
    if (code == cfg_regs[CFG_BATT_CODE]) return KIND_BATTERY;
    if (code == cfg_regs[CFG_CURR_CODE]) return KIND_CURRENT;
    if (code == cfg_regs[CFG_VER_CODE]) return KIND_VERSION;
    return KIND_BAD;
  endfunction

  function automatic logic [4:0] reply_bytes(input kind_t k);
    case (k)
      KIND_DRIVE:   return 5'd1;
      KIND_BATTERY: return 5'd4;
      KIND_CURRENT: return 5'd6;
      KIND_VERSION: return 5'd27;
      default:      return 5'd0;
    endcase
  endfunction

  task automatic predict_frame(input logic [7:0] b, input logic last);
    logic [7:0]  bytes_out[$];
    frame_word_t w;
    if (!pkt_open) begin
      pkt_kind = classify_code(b);
      crc_acc = 16'h0000;
      pkt_count = 0;
      pkt_ovf = 1'b0;
      if (pkt_kind == KIND_BAD) begin
        w = '{tx: 8'h00, fend: 1'b1, rlen: 5'd0, bad: 1'b1, ovf: 1'b0};
        pending_tx.push_back(w);
        pkt_open = !last;
        pkt_drop = !last;
        return;
      end
      pkt_open = 1'b1;
      pkt_drop = 1'b0;
      crc_acc = crc16_byte(crc_acc, cfg_regs[CFG_DEV_ADDR]);
      crc_acc = crc16_byte(crc_acc, b);
      bytes_out.push_back(cfg_regs[CFG_DEV_ADDR]);
      bytes_out.push_back(b);
      pkt_count = 1;
    end else if (pkt_drop) begin
      if (last) begin
        pkt_open = 1'b0;
        pkt_drop = 1'b0;
      end
      return;
    end else if (pkt_count < PAYLOAD_CAP) begin
      crc_acc = crc16_byte(crc_acc, b);
      bytes_out.push_back(b);
      pkt_count++;
    end else begin
      pkt_ovf = 1'b1;
    end
    if (last) begin
      if (pkt_kind == KIND_DRIVE) begin
        bytes_out.push_back(crc_acc[15:8]);
        bytes_out.push_back(crc_acc[7:0]);
      end else if (bytes_out.size() == 0) begin
        // A read frame that ends on a dropped byte is closed by a marker word.
        bytes_out.push_back(8'h00);
      end
      pkt_open = 1'b0;
    end
    foreach (bytes_out[i]) begin
      w.tx = bytes_out[i];
      w.fend = last && (i == bytes_out.size() - 1);
      w.rlen = reply_bytes(pkt_kind);
      w.bad = 1'b0;
      w.ovf = pkt_ovf;
      pending_tx.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    frame_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tx.size() == 0) begin
        report_mismatch("unexpected word, tx_byte", out_tx_byte, 0);
      end else begin
        w = pending_tx.pop_front();
        if (out_tx_byte !== w.tx) report_mismatch("tx_byte", out_tx_byte, w.tx);
        if (out_frame_end !== w.fend) report_mismatch("frame_end", out_frame_end, w.fend);
        if (out_reply_length !== w.rlen) begin
          report_mismatch("reply_length", out_reply_length, w.rlen);
        end
        if (out_bad_command !== w.bad) report_mismatch("bad_command", out_bad_command, w.bad);
        if (out_overflow !== w.ovf) report_mismatch("overflow", out_overflow, w.ovf);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_payload_byte <= b;
    in_payload_end <= last;
    do @(posedge clk); while (!in_ready);
    predict_frame(b, last);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] code, input int len);
    send_word(code, len == 1);
    for (int i = 1; i < len; i++) begin
      send_word(8'($urandom), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    int spins;
    spins = 0;
    in_valid <= 1'b0;
    while (pending_tx.size() != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk);
      spins++;
    end
    if (pending_tx.size() != 0) begin
      report_mismatch("words never delivered", 0, pending_tx.size());
      pending_tx.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= CFG_VER_CODE) cfg_regs[idx] = val;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [7:0] m1, input logic [7:0] m2,
                            input logic [7:0] batt, input logic [7:0] curr,
                            input logic [7:0] ver);
    wait_drained();
    write_reg(CFG_DEV_ADDR, addr);
    write_reg(CFG_M1_CODE, m1);
    write_reg(CFG_M2_CODE, m2);
    write_reg(CFG_BATT_CODE, batt);
    write_reg(CFG_CURR_CODE, curr);
    write_reg(CFG_VER_CODE, ver);
    // Indexes past the register list must leave every register untouched.
    write_reg(CFG_SPARE_LO, 8'($urandom));
    write_reg(CFG_SPARE_HI, 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_packet();
    logic [7:0] code;
    int         len;
    if ($urandom_range(99) < 80) begin
      code = cfg_regs[3'($urandom_range(1, 5))];
    end else begin
      code = 8'($urandom);
    end
    len = ($urandom_range(99) < 90) ? int'($urandom_range(1, 6)) : int'($urandom_range(7, 20));
    send_packet(code, len);
  endtask

  task automatic test_command_kinds();
    send_word(M1_CODE_RST, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(M2_CODE_RST, 1'b1);
    send_word(BATT_CODE_RST, 1'b0);
    send_word(8'h5A, 1'b1);
    send_word(CURR_CODE_RST, 1'b1);
    send_word(VER_CODE_RST, 1'b1);
  endtask

  task automatic test_unknown_command();
    send_word(8'hFF, 1'b0);
    send_word(8'h12, 1'b0);
    send_word(8'h34, 1'b1);
    send_word(8'h7E, 1'b1);
    send_word(BATT_CODE_RST, 1'b1);
  endtask

  task automatic test_register_extremes();
    // Battery and current codes repeat the drive codes, so the drive kind must win.
    set_config(8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'h00, 1'b1);
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b1);
    set_config(8'h00, 8'h10, 8'h20, 8'h30, 8'h30, 8'h30);
    send_word(8'h30, 1'b1);
    send_word(8'h20, 1'b0);
    send_word(8'hA5, 1'b1);
  endtask

  task automatic test_payload_overflow();
    set_config(DEV_ADDR_RST, M1_CODE_RST, M2_CODE_RST, BATT_CODE_RST, CURR_CODE_RST,
               VER_CODE_RST);
    in_idle_pct = 55;
    out_stall_pct = 0;
    send_packet(M2_CODE_RST, PAYLOAD_CAP + 2);
    in_idle_pct = 0;
    out_stall_pct = 55;
    send_packet(BATT_CODE_RST, PAYLOAD_CAP + 1);
  endtask

  task automatic test_backpressure();
    wait_drained();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_cycles = 150;
    for (int i = 0; i < 3; i++) begin
      send_packet(cfg_regs[3'($urandom_range(1, 5))], 3);
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int start;
    set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom));
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    start = words_sent;
    while (words_sent - start < count) send_random_packet();
  endtask

  initial begin
    cfg_regs[CFG_DEV_ADDR] = DEV_ADDR_RST;
    cfg_regs[CFG_M1_CODE] = M1_CODE_RST;
    cfg_regs[CFG_M2_CODE] = M2_CODE_RST;
    cfg_regs[CFG_BATT_CODE] = BATT_CODE_RST;
    cfg_regs[CFG_CURR_CODE] = CURR_CODE_RST;
    cfg_regs[CFG_VER_CODE] = VER_CODE_RST;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_command_kinds();
    test_unknown_command();
    test_register_extremes();
    test_payload_overflow();
    test_backpressure();
    test_random_traffic(9, 9, 10);
    wait_drained();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### motor_command_packet_framer.f
rtl/core/mcpf_pkg.sv
rtl/core/mcpf_front.sv
rtl/core/mcpf_queue.sv
rtl/core/mcpf_back.sv
rtl/core/motor_command_packet_framer.sv
sim/tb.sv
